// File: hw/rtl/asl_pkg.sv
// asl_pkg: shared types and constants for the assembly source lexer
// no dependencies
`timescale 1ns / 1ps

package asl_pkg;

   // fixed widths of the token fields
   localparam int unsigned KIND_BITS = 5;
   localparam int unsigned CODE_BITS = 4;
   localparam int unsigned FIELD_BITS = 32;

   // token kinds
   localparam logic [KIND_BITS-1:0] K_START   = 5'd0;
   localparam logic [KIND_BITS-1:0] K_END     = 5'd1;
   localparam logic [KIND_BITS-1:0] K_BREAK   = 5'd2;
   localparam logic [KIND_BITS-1:0] K_DOT     = 5'd3;
   localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd4;
   localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd5;
   localparam logic [KIND_BITS-1:0] K_EQUAL   = 5'd6;
   localparam logic [KIND_BITS-1:0] K_DOLLAR  = 5'd7;
   localparam logic [KIND_BITS-1:0] K_AT      = 5'd8;
   localparam logic [KIND_BITS-1:0] K_COLON   = 5'd9;
   localparam logic [KIND_BITS-1:0] K_HASH    = 5'd10;
   localparam logic [KIND_BITS-1:0] K_PERCENT = 5'd11;
   localparam logic [KIND_BITS-1:0] K_STRING  = 5'd12;
   localparam logic [KIND_BITS-1:0] K_CHAR    = 5'd13;
   localparam logic [KIND_BITS-1:0] K_COMMENT = 5'd14;
   localparam logic [KIND_BITS-1:0] K_NAME    = 5'd15;
   localparam logic [KIND_BITS-1:0] K_DEC     = 5'd16;
   localparam logic [KIND_BITS-1:0] K_BIN     = 5'd17;
   localparam logic [KIND_BITS-1:0] K_OCT     = 5'd18;
   localparam logic [KIND_BITS-1:0] K_HEX     = 5'd19;
   localparam logic [KIND_BITS-1:0] K_ERROR   = 5'd20;

   // error codes
   localparam logic [CODE_BITS-1:0] E_NONE     = 4'd0;
   localparam logic [CODE_BITS-1:0] E_SYNTAX   = 4'd0;
   localparam logic [CODE_BITS-1:0] E_NAME     = 4'd1;
   localparam logic [CODE_BITS-1:0] E_ZERO     = 4'd2;
   localparam logic [CODE_BITS-1:0] E_DEC      = 4'd3;
   localparam logic [CODE_BITS-1:0] E_BIN      = 4'd4;
   localparam logic [CODE_BITS-1:0] E_OCT      = 4'd5;
   localparam logic [CODE_BITS-1:0] E_HEX      = 4'd6;
   localparam logic [CODE_BITS-1:0] E_STR_LINE = 4'd7;
   localparam logic [CODE_BITS-1:0] E_CHR_LINE = 4'd8;
   localparam logic [CODE_BITS-1:0] E_CHR_MULTI = 4'd9;

   // scanner modes, one-hot
   typedef enum logic [8:0] {
      M_BLANK = 9'b000000001,
      M_NAME  = 9'b000000010,
      M_NUM   = 9'b000000100,
      M_BIN   = 9'b000001000,
      M_OCT   = 9'b000010000,
      M_HEX   = 9'b000100000,
      M_STR   = 9'b001000000,
      M_CHR   = 9'b010000000,
      M_COM   = 9'b100000000
   } mode_type;

   // input item
   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_input;
   } req_type;

   // result item
   typedef struct packed {
      logic [KIND_BITS-1:0]  token_kind;
      logic [CODE_BITS-1:0]  error_code;
      logic [FIELD_BITS-1:0] first_position;
      logic [FIELD_BITS-1:0] final_position;
      logic [FIELD_BITS-1:0] start_column;
      logic [FIELD_BITS-1:0] line_number;
      logic                  last_of_run;
   } rsp_type;

   // separator class
   function automatic logic is_sep(input logic [7:0] c);
      case (c)
         8'h20, 8'h09, 8'h0C, 8'h0A, 8'h0D, 8'h2E, 8'h2B, 8'h2D, 8'h3D,
         8'h24, 8'h40, 8'h3A, 8'h23, 8'h25, 8'h22, 8'h27, 8'h3B: is_sep = 1'b1;
         default: is_sep = 1'b0;
      endcase
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      is_dig = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_lead(input logic [7:0] c);
      is_lead = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
         || (c == 8'h5F);
   endfunction

   function automatic logic is_hexd(input logic [7:0] c);
      is_hexd = is_dig(c) || ((c >= 8'h61) && (c <= 8'h66))
         || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

endpackage

// File: hw/rtl/asl_front.sv
// asl_front: scanner state machine, turns each byte into up to two tokens
// depends on asl_pkg
`timescale 1ns / 1ps

module asl_front #(
   parameter int unsigned POSITION_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  asl_pkg::req_type  req_data,
   output logic              tok_valid,
   output logic [1:0]        tok_count,
   output asl_pkg::rsp_type  tok_a,
   output asl_pkg::rsp_type  tok_b,
   input  logic              tok_ready
);
   import asl_pkg::*;

   typedef logic [POSITION_BITS-1:0] pos_type;

   mode_type                 mode_ff, mode_in;
   logic                     esc_ff, esc_in;
   logic                     zero_ff, zero_in;
   logic                     firstc_ff, firstc_in;
   pos_type                  idx_ff, idx_in;
   pos_type                  col_ff, col_in;
   pos_type                  line_ff, line_in;
   pos_type                  tfirst_ff, tfirst_in;
   pos_type                  tcol_ff, tcol_in;
   logic [KIND_BITS-1:0]     tkind_ff, tkind_in;
   logic                     started_ff, started_in;
   logic                     halted_ff, halted_in;

   rsp_type                  res [2];
   logic [1:0]               nres;
   logic                     fire;

   assign fire      = req_valid && req_ready;
   assign req_ready = tok_ready;
   assign tok_valid = req_valid && !halted_ff;
   assign tok_count = nres;
   assign tok_a     = res[0];
   assign tok_b     = res[1];

   function automatic logic [FIELD_BITS-1:0] f32(input pos_type v);
      logic [POSITION_BITS+FIELD_BITS-1:0] w;
      w = {{FIELD_BITS{1'b0}}, v};
      f32 = w[FIELD_BITS-1:0];
   endfunction

   // next-state and token generation
   always_comb begin
      logic [7:0] c;
      logic       again;
      logic       pass;
      rsp_type    t;
      c = req_data.source_byte;
      mode_in = mode_ff; esc_in = esc_ff; zero_in = zero_ff; firstc_in = firstc_ff;
      idx_in = idx_ff; col_in = col_ff; line_in = line_ff;
      tfirst_in = tfirst_ff; tcol_in = tcol_ff; tkind_in = tkind_ff;
      started_in = started_ff; halted_in = halted_ff;
      res[0] = '0; res[1] = '0; nres = 2'd0;
      again = 1'b0;
      if (!halted_ff) begin
         if (!started_ff) begin
            res[0] = '0;
            res[0].token_kind = K_START;
            nres = 2'd1;
            started_in = 1'b1;
         end
         if (req_data.end_of_input) begin
            t = '0;
            t.token_kind = K_END;
            t.first_position = f32(idx_ff + 1'b1);
            t.final_position = f32(idx_ff + 1'b1);
            t.start_column = f32(col_ff + 1'b1);
            t.line_number = f32(line_ff);
            res[nres[0]] = t;
            nres = nres + 2'd1;
            mode_in = M_BLANK;
            halted_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            col_in = col_ff + 1'b1;
            // two passes at most: the second only in blank mode after a yield
            for (int p = 0; p < 2; p++) begin
               pass = (p == 0) || (again && !halted_in);
               again = 1'b0;
               t = '0;
               t.first_position = f32(idx_in);
               t.final_position = f32(idx_in);
               t.start_column = f32(col_in);
               t.line_number = f32(line_in);
               if (pass && nres < 2'd2) begin
                  unique case (mode_in)
                     M_BLANK: begin
                        case (c)
                           8'h20, 8'h09, 8'h0D, 8'h0C: ;
                           8'h0A: begin
                              t.token_kind = K_BREAK;
                              res[nres[0]] = t; nres = nres + 2'd1;
                              col_in = '1;
                              line_in = line_in + 1'b1;
                           end
                           8'h2E, 8'h2B, 8'h2D, 8'h3D, 8'h24, 8'h40, 8'h3A, 8'h23,
                           8'h25: begin
                              case (c)
                                 8'h2E: t.token_kind = K_DOT;
                                 8'h2B: t.token_kind = K_PLUS;
                                 8'h2D: t.token_kind = K_MINUS;
                                 8'h3D: t.token_kind = K_EQUAL;
                                 8'h24: t.token_kind = K_DOLLAR;
                                 8'h40: t.token_kind = K_AT;
                                 8'h3A: t.token_kind = K_COLON;
                                 8'h23: t.token_kind = K_HASH;
                                 default: t.token_kind = K_PERCENT;
                              endcase
                              res[nres[0]] = t; nres = nres + 2'd1;
                           end
                           default: begin
                              tfirst_in = idx_in; tcol_in = col_in;
                              esc_in = 1'b0; zero_in = 1'b0; firstc_in = 1'b0;
                              if (c == 8'h22) begin
                                 mode_in = M_STR; tkind_in = K_STRING;
                              end else if (c == 8'h27) begin
                                 mode_in = M_CHR; tkind_in = K_CHAR; firstc_in = 1'b1;
                              end else if (c == 8'h3B) begin
                                 mode_in = M_COM; tkind_in = K_COMMENT;
                              end else if (is_lead(c)) begin
                                 mode_in = M_NAME; tkind_in = K_NAME;
                              end else if (is_dig(c)) begin
                                 mode_in = M_NUM; tkind_in = K_DEC;
                                 zero_in = (c == 8'h30); firstc_in = 1'b1;
                              end else begin
                                 tfirst_in = tfirst_ff; tcol_in = tcol_ff;
                                 esc_in = esc_ff; zero_in = zero_ff; firstc_in = firstc_ff;
                                 t.token_kind = K_ERROR; t.error_code = E_SYNTAX;
                                 res[nres[0]] = t; nres = nres + 2'd1;
                                 halted_in = 1'b1;
                              end
                           end
                        endcase
                     end
                     M_NAME: begin
                        if (is_sep(c)) again = 1'b1;
                        else if (!(is_lead(c) || is_dig(c))) begin
                           t.token_kind = K_ERROR; t.error_code = E_NAME;
                           res[nres[0]] = t; nres = nres + 2'd1; halted_in = 1'b1;
                        end
                     end
                     M_NUM: begin
                        if (is_sep(c)) begin
                           if (!firstc_in && zero_in) begin
                              t.token_kind = K_ERROR; t.error_code = E_ZERO;
                              res[nres[0]] = t; nres = nres + 2'd1; halted_in = 1'b1;
                           end else again = 1'b1;
                        end else if (firstc_in && zero_in &&
                                     (c == 8'h62 || c == 8'h42)) begin
                           mode_in = M_BIN; tkind_in = K_BIN; firstc_in = 1'b1;
                        end else if (firstc_in && zero_in &&
                                     (c == 8'h6F || c == 8'h4F)) begin
                           mode_in = M_OCT; tkind_in = K_OCT; firstc_in = 1'b1;
                        end else if (firstc_in && zero_in &&
                                     (c == 8'h78 || c == 8'h58)) begin
                           mode_in = M_HEX; tkind_in = K_HEX; firstc_in = 1'b1;
                        end else begin
                           firstc_in = 1'b0;
                           if (!is_dig(c)) begin
                              t.token_kind = K_ERROR; t.error_code = E_DEC;
                              res[nres[0]] = t; nres = nres + 2'd1; halted_in = 1'b1;
                           end
                        end
                     end
                     M_BIN, M_OCT, M_HEX: begin
                        t.token_kind = K_ERROR;
                        t.error_code = (mode_in == M_BIN) ? E_BIN :
                                       (mode_in == M_OCT) ? E_OCT : E_HEX;
                        if (is_sep(c)) begin
                           if (firstc_in) begin
                              res[nres[0]] = t; nres = nres + 2'd1; halted_in = 1'b1;
                           end else again = 1'b1;
                        end else begin
                           firstc_in = 1'b0;
                           if (!((mode_in == M_BIN && (c == 8'h30 || c == 8'h31)) ||
                                 (mode_in == M_OCT && c >= 8'h30 && c <= 8'h37) ||
                                 (mode_in == M_HEX && is_hexd(c)))) begin
                              res[nres[0]] = t; nres = nres + 2'd1; halted_in = 1'b1;
                           end
                        end
                     end
                     M_STR, M_CHR: begin
                        if (c == 8'h0A) begin
                           t.token_kind = K_ERROR;
                           t.error_code = (mode_in == M_STR) ? E_STR_LINE : E_CHR_LINE;
                           res[nres[0]] = t; nres = nres + 2'd1; halted_in = 1'b1;
                        end else if (esc_in) esc_in = 1'b0;
                        else if (c == 8'h5C) esc_in = 1'b1;
                        else if ((mode_in == M_STR && c == 8'h22) ||
                                 (mode_in == M_CHR && c == 8'h27)) begin
                           t.token_kind = tkind_in;
                           t.first_position = f32(tfirst_in);
                           t.start_column = f32(tcol_in);
                           res[nres[0]] = t; nres = nres + 2'd1;
                           mode_in = M_BLANK;
                        end else if (mode_in == M_STR || firstc_in) firstc_in = 1'b0;
                        else begin
                           t.token_kind = K_ERROR; t.error_code = E_CHR_MULTI;
                           res[nres[0]] = t; nres = nres + 2'd1; halted_in = 1'b1;
                        end
                     end
                     M_COM: begin
                        if (c == 8'h0A) again = 1'b1;
                     end
                     default: mode_in = M_BLANK;
                  endcase
                  // separator-ended token: yield up to the previous byte
                  if (again) begin
                     t = '0;
                     t.token_kind = tkind_in;
                     t.first_position = f32(tfirst_in);
                     t.final_position = f32(idx_in - 1'b1);
                     t.start_column = f32(tcol_in);
                     t.line_number = f32(line_in);
                     res[nres[0]] = t; nres = nres + 2'd1;
                     mode_in = M_BLANK;
                  end
               end
            end
         end
         if (nres == 2'd1) res[0].last_of_run = 1'b1;
         if (nres == 2'd2) res[1].last_of_run = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_BLANK; esc_ff <= 1'b0; zero_ff <= 1'b0; firstc_ff <= 1'b0;
         idx_ff <= '1; col_ff <= '1; line_ff <= '0;
         tfirst_ff <= '0; tcol_ff <= '0; tkind_ff <= K_START;
         started_ff <= 1'b0; halted_ff <= 1'b0;
      end else if (fire) begin
         mode_ff <= mode_in; esc_ff <= esc_in; zero_ff <= zero_in; firstc_ff <= firstc_in;
         idx_ff <= idx_in; col_ff <= col_in; line_ff <= line_in;
         tfirst_ff <= tfirst_in; tcol_ff <= tcol_in; tkind_ff <= tkind_in;
         started_ff <= started_in; halted_ff <= halted_in;
      end
   end

endmodule

// File: hw/rtl/asl_queue.sv
// asl_queue: scanner-to-output queue, up to two tokens a cycle with two slots free
// depends on asl_pkg
`timescale 1ns / 1ps

module asl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [1:0]       push_count,
   input  asl_pkg::rsp_type push_a,
   input  asl_pkg::rsp_type push_b,
   output logic             push_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output asl_pkg::rsp_type rsp_data
);
   import asl_pkg::*;

   localparam int unsigned DEPTH = 4;

   rsp_type    mem_ff [DEPTH];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop, push;
   logic [2:0] pushed;

   // ready when room for two even with no pop
   assign push_ready = (cnt_ff <= 3'd2);
   assign push       = push_valid && push_ready;
   assign pushed     = push ? {1'b0, push_count} : 3'd0;
   assign rsp_valid  = (cnt_ff != 3'd0);
   assign pop        = rsp_valid && rsp_ready;
   assign rsp_data   = mem_ff[rd_ff];
   assign wr_in      = wr_ff + pushed[1:0];
   assign rd_in      = rd_ff + {1'b0, pop};
   assign cnt_in     = cnt_ff + pushed - {2'b00, pop};

   // storage
   always_ff @(posedge clock) begin
      if (push && push_count != 2'd0) mem_ff[wr_ff] <= push_a;
      if (push && push_count == 2'd2) mem_ff[wr_ff + 2'd1] <= push_b;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/assembly_source_lexer_unit.sv
// assembly_source_lexer_unit: top level of the assembly source lexer
// depends on asl_pkg, asl_front, asl_queue
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (source_byte, end_of_input)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (token fields)
//
// one byte per cycle while req_ready is high; scanner tokens are combinational
// a byte yields zero, one or two tokens into a four-entry queue
// req_ready drops only while the queue holds three or more tokens
// synchronous reset clears scanner state and queue pointers
// after an error or end token all later bytes are taken and dropped

module assembly_source_lexer_unit #(
   parameter int unsigned POSITION_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  asl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output asl_pkg::rsp_type rsp_data
);
   import asl_pkg::*;

   logic       tok_valid, tok_ready;
   logic [1:0] tok_count;
   rsp_type    tok_a, tok_b;

   // scanner
   asl_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .tok_valid, .tok_count, .tok_a, .tok_b, .tok_ready
   );

   // token queue
   asl_queue u_queue (
      .clock, .reset,
      .push_valid(tok_valid), .push_count(tok_count), .push_a(tok_a), .push_b(tok_b),
      .push_ready(tok_ready), .rsp_valid, .rsp_ready, .rsp_data
   );

`ifndef SYNTHESIS
   // an error token always closes the run of its byte
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == K_ERROR |-> rsp_data.last_of_run)
      else $error("error token not last of run");
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind != K_ERROR |-> rsp_data.error_code == E_NONE)
      else $error("error code on non-error token");
   // a waiting token stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("waiting token changed");
`endif

endmodule
